// File: hdl/qct_pkg.sv
// Shared types, character codes and size constants for the quoted command tokenizer.
// No dependencies; every other file imports this package.
package qct_pkg;

    localparam int MAX_ARGS = 16;
    localparam int MAX_LEN  = 1024;
    localparam int ARGC_W   = $clog2(MAX_ARGS + 1);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int NUM_W    = 5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_QUOTE = 2'd1,
        ST_MANY  = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'b001,
        MODE_PLAIN   = 3'b010,
        MODE_QUOTED  = 3'b100
    } mode_t;

    typedef struct packed {
        logic              parity;
        mode_t             mode;
        logic              skip;
        logic [ARGC_W-1:0] argc;
        logic [LEN_W-1:0]  len;
        status_t           err;
    } qct_state_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       ch;
        logic [NUM_W-1:0] num;
        status_t          st;
    } qct_res_t;

    typedef struct packed {
        qct_res_t res;
        logic     last;
    } qct_entry_t;

    localparam qct_state_t STATE_CLEAR = '{
        parity: 1'b0, mode: MODE_BETWEEN, skip: 1'b0,
        argc: '0, len: '0, err: ST_OK
    };

    // argument index / count as carried on the output, kept to its low bits
    function automatic logic [NUM_W-1:0] to_num(input logic [ARGC_W-1:0] a);
        logic [ARGC_W+NUM_W-1:0] wide;
        wide = {{NUM_W{1'b0}}, a};
        return wide[NUM_W-1:0];
    endfunction

    function automatic qct_res_t mk_res(input kind_t k, input logic [7:0] c,
                                        input logic [ARGC_W-1:0] a, input status_t s);
        qct_res_t r;
        r.kind = k;
        r.ch   = c;
        r.num  = to_num(a);
        r.st   = s;
        return r;
    endfunction

endpackage

// File: hdl/qct_step.sv
// Per-byte tokenizer logic: next state and up to two result items for one input byte.
// Purely combinational; depends on qct_pkg.
module qct_step
    import qct_pkg::*;
(
    input  qct_state_t  cur,
    input  logic [7:0]  in_byte,
    output qct_state_t  nxt,
    output logic [1:0]  res_cnt,
    output qct_res_t    res0,
    output qct_res_t    res1
);

    logic       is_space;
    logic       is_delim;
    logic       is_quote;
    logic       arg_room;

    // message-done path
    logic [1:0] fin_cnt;
    qct_res_t   fin_r0;
    qct_res_t   fin_r1;

    // ordinary byte path
    qct_state_t tk_state;
    logic       tk_emit;
    qct_res_t   tk_r;
    logic [LEN_W-1:0] len_inc;

    assign is_space = (in_byte == CH_SP) || (in_byte == CH_TAB);
    assign is_delim = in_byte inside {CH_SEMI, CH_CR, CH_LF};
    assign is_quote = (in_byte == CH_QUOTE);
    assign arg_room = (cur.argc < ARGC_W'(MAX_ARGS));

    always_comb
    begin
        fin_cnt = 2'd1;
        fin_r1  = mk_res(KIND_DONE, CH_NUL, cur.argc, cur.err);
        fin_r0  = mk_res(KIND_DONE, CH_NUL, cur.argc, cur.err);
        if (cur.err == ST_OK && cur.mode == MODE_PLAIN)
        begin
            if (arg_room)
            begin
                fin_cnt = 2'd2;
                fin_r0  = mk_res(KIND_END, CH_NUL, cur.argc, ST_OK);
                fin_r1  = mk_res(KIND_DONE, CH_NUL, cur.argc + ARGC_W'(1), ST_OK);
            end
            else
            begin
                fin_r0 = mk_res(KIND_DONE, CH_NUL, cur.argc, ST_MANY);
            end
        end
        else if (cur.err == ST_OK && cur.mode == MODE_QUOTED)
        begin
            fin_r0 = mk_res(KIND_DONE, CH_NUL, cur.argc, ST_QUOTE);
        end
    end

    always_comb
    begin
        tk_state        = cur;
        tk_state.skip   = 1'b0;
        tk_state.parity = cur.parity ^ is_quote;
        tk_emit         = 1'b0;
        tk_r            = mk_res(KIND_BYTE, in_byte, cur.argc, ST_OK);
        len_inc         = cur.len + LEN_W'(1);
        if (cur.len < LEN_W'(MAX_LEN))
        begin
            tk_state.len = len_inc;
        end
        if (tk_state.len == LEN_W'(MAX_LEN))
        begin
            tk_state.err = ST_LONG;
        end
        if (tk_state.err == ST_OK)
        begin
            case (cur.mode)
                MODE_PLAIN, MODE_QUOTED:
                begin
                    // plain ends at a space, quoted at the closing quote
                    if ((cur.mode == MODE_PLAIN) ? is_space : is_quote)
                    begin
                        tk_state.mode = MODE_BETWEEN;
                        if (arg_room)
                        begin
                            tk_emit       = 1'b1;
                            tk_r          = mk_res(KIND_END, CH_NUL, cur.argc, ST_OK);
                            tk_state.argc = cur.argc + ARGC_W'(1);
                        end
                        else
                        begin
                            tk_state.err = ST_MANY;
                        end
                    end
                    else
                    begin
                        tk_emit = arg_room;
                    end
                end
                default:
                begin
                    if (is_space)
                    begin
                        tk_state.mode = MODE_BETWEEN;
                    end
                    else if (is_quote)
                    begin
                        tk_state.mode = MODE_QUOTED;
                    end
                    else
                    begin
                        tk_state.mode = MODE_PLAIN;
                        tk_emit       = arg_room;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        nxt     = cur;
        res_cnt = 2'd0;
        res0    = fin_r0;
        res1    = fin_r1;
        if (in_byte == CH_NUL)
        begin
            nxt = STATE_CLEAR;
            if (!cur.skip)
            begin
                res_cnt = fin_cnt;
            end
        end
        else if (cur.skip && (is_delim || is_space))
        begin
            nxt = cur;
        end
        else if (is_delim && !cur.parity)
        begin
            nxt      = STATE_CLEAR;
            nxt.skip = 1'b1;
            res_cnt  = fin_cnt;
        end
        else
        begin
            nxt     = tk_state;
            res_cnt = {1'b0, tk_emit};
            res0    = tk_r;
        end
    end

endmodule

// File: hdl/qct_out_buf.sv
// Two-entry result buffer between the tokenizer logic and the output channel.
// Marks the final result of each input byte; depends on qct_pkg.
module qct_out_buf
    import qct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [1:0] push_n,
    input  qct_res_t   push_r0,
    input  qct_res_t   push_r1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output qct_entry_t head
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    qct_entry_t q0_reg;
    qct_entry_t q0_next;
    qct_entry_t q1_reg;
    qct_entry_t q1_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // a push lands only in an empty buffer or in one whose single entry is taken in the same cycle
    assign room      = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign head      = q0_reg;

    always_comb
    begin
        count_next = count_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        if (push)
        begin
            count_next   = push_n;
            q0_next.res  = push_r0;
            q0_next.last = (push_n == 2'd1);
            q1_next.res  = push_r1;
            q1_next.last = 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            q0_next    = q1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_n == 2'd2) |=> (count_reg == 2'd2 && !q0_reg.last && q1_reg.last))
        else $error("result pair not held with last mark on second");
`endif

endmodule

// File: hdl/quoted_command_tokenizer_unit.sv
// Top level of the quoted command tokenizer: state registers, per-byte logic, result buffer.
// Depends on qct_pkg, qct_step and qct_out_buf.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_ready  | in_byte
//  output  | out_valid / out_ready| kind, out_char, arg_number, status, last_of_step
//
// One byte is taken per cycle while the result buffer has room; its results are in the
// result buffer the next cycle. A byte with two results (argument end plus message done)
// holds the input while the buffer drains. While the single waiting result is being taken,
// a new byte is accepted in the same cycle. Reset clears the tokenizer state and empties
// the buffer; no clearing pass is needed.
module quoted_command_tokenizer_unit
    import qct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       out_char,
    output logic [NUM_W-1:0] arg_number,
    output logic [1:0]       status,
    output logic             last_of_step
);

    qct_state_t state_reg;
    qct_state_t state_next;
    qct_state_t step_state;
    logic [1:0] res_cnt;
    qct_res_t   res0;
    qct_res_t   res1;
    logic       accept;
    qct_entry_t head;

    assign accept = in_valid && in_ready;

    qct_step u_step (
        .cur     (state_reg),
        .in_byte (in_byte),
        .nxt     (step_state),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    qct_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_n    (res_cnt),
        .push_r0   (res0),
        .push_r1   (res1),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign state_next   = accept ? step_state : state_reg;
    assign kind         = head.res.kind;
    assign out_char     = head.res.ch;
    assign arg_number   = head.res.num;
    assign status       = head.res.st;
    assign last_of_step = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_byte == CH_NUL) |=>
            (state_reg.argc == '0 && state_reg.len == '0 && state_reg.err == ST_OK
             && !state_reg.skip && !state_reg.parity))
        else $error("text end did not clear tokenizer state");

    a_delim_sets_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !state_reg.skip && !state_reg.parity
         && (in_byte == CH_SEMI || in_byte == CH_CR || in_byte == CH_LF))
            |=> (state_reg.skip && out_valid))
        else $error("message end at delimiter not followed by skip and done item");
`endif

endmodule
